// File: rtl/rmed_pkg.sv
// Shared types, widths and constants for the rotation matrix to Euler angle block.
package rmed_pkg;

    localparam int ELEM_W       = 16;
    localparam int ANG_W        = 16;
    localparam int THR_W        = 15;
    localparam int ANGLE_FRAC   = 7;
    localparam int ACC_FRAC     = 24;
    localparam int PRESCALE_SH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 36;   // CORDIC datapath width
    localparam int OPW          = 17;   // CORDIC operand width
    localparam int SQ_IN_W      = 32;
    localparam int SQ_OUT_W     = 16;
    localparam int SQ_REM_W     = 18;
    localparam int CO_LAT       = CORDIC_STEPS + 2;
    localparam int ANG_LIM      = 180 << ANGLE_FRAC;
    localparam int RND_SH       = ACC_FRAC - ANGLE_FRAC;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        t_elem m00;
        t_elem m10;
        t_elem m20;
        t_elem m21;
        t_elem m22;
        t_elem m12;
        t_elem m11;
    } t_elems;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_TAB [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
        7, 4, 2, 1, 0
    };

    function automatic logic signed [CW-1:0] atan_deg(input int idx);
        atan_deg = CW'(ATAN_TAB[idx]);
    endfunction

endpackage

// File: rtl/rotation_matrix_to_euler_degrees_top.sv
// Top level: rotation matrix to XYZ Euler angles in degrees, fully pipelined.
//
// Takes one matrix beat per clock while o_stall is low and returns one angle
// beat per matrix, in order. The datapath is 38 register stages deep, in
// this order: input register, squaring, sum, a 16-stage bit-per-stage square
// root, a formula-select stage, and three parallel 18-stage CORDIC pipelines
// (prerotate, 16 micro-rotations, round/saturate) whose last stage is the
// output register. The whole pipe advances as one: it freezes only while a
// finished beat sits at the output and the sink stalls, so o_stall is
// exactly that condition. The singular threshold is a Q1.14 register (reset 1)
// on a valid/ready port that is always ready; write it only while idle.
// Singular matrices have roll forced to 0 by feeding the roll CORDIC a zero
// vector.
module rotation_matrix_to_euler_degrees_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // matrix in
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m00,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m10,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m20,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m21,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m22,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m12,
    input  logic signed [rmed_pkg::ELEM_W-1:0]  i_m11,
    // angles out
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rmed_pkg::ANG_W-1:0]   o_pitch_deg,
    output logic signed [rmed_pkg::ANG_W-1:0]   o_yaw_deg,
    output logic signed [rmed_pkg::ANG_W-1:0]   o_roll_deg,
    output logic                                o_is_singular,
    // threshold register write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rmed_pkg::THR_W-1:0]          i_cfg_data
);

    localparam int OPW = rmed_pkg::OPW;

    logic en;
    logic r_out_vld_any;

    // global advance: hold only when a beat waits at the output
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    // threshold register
    logic [rmed_pkg::THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rmed_pkg::THR_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // stage 1: input register
    logic             r1_vld;
    rmed_pkg::t_elems r1_m;
    // stage 2: squares
    logic             r2_vld;
    rmed_pkg::t_elems r2_m;
    logic [30:0]      r2_sq0, r2_sq1;
    // stage 3: sum of squares
    logic             r3_vld;
    rmed_pkg::t_elems r3_m;
    logic [rmed_pkg::SQ_IN_W-1:0] r3_sum;

    logic signed [31:0] n_sq0, n_sq1;
    assign n_sq0 = r1_m.m00 * r1_m.m00;
    assign n_sq1 = r1_m.m20 * r1_m.m20;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (en) begin
            r1_m   <= '{m00: i_m00, m10: i_m10, m20: i_m20, m21: i_m21,
                        m22: i_m22, m12: i_m12, m11: i_m11};
            r2_m   <= r1_m;
            r2_sq0 <= n_sq0[30:0];
            r2_sq1 <= n_sq1[30:0];
            r3_m   <= r2_m;
            r3_sum <= {1'b0, r2_sq0} + {1'b0, r2_sq1};
        end
    end

    // square root
    logic                            sq_vld;
    logic [rmed_pkg::SQ_OUT_W-1:0]   sq_root;
    rmed_pkg::t_elems                sq_m;

    rmed_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_val   (r3_sum),
        .i_side  (r3_m),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_m)
    );

    // select stage: singular test and CORDIC operands
    logic                   r4_vld;
    logic                   r4_sing;
    logic signed [OPW-1:0]  r4_py, r4_px, r4_yy, r4_yx, r4_ry, r4_rx;
    logic                   n_sing;

    assign n_sing = sq_root < {1'b0, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= sq_vld;
        end
        if (en) begin
            r4_sing <= n_sing;
            r4_yy   <= -OPW'(sq_m.m20);
            r4_yx   <= OPW'({1'b0, sq_root});
            if (n_sing) begin
                r4_py <= -OPW'(sq_m.m12);
                r4_px <= OPW'(sq_m.m11);
                r4_ry <= '0;     // zero vector: roll comes out 0
                r4_rx <= '0;
            end else begin
                r4_py <= OPW'(sq_m.m21);
                r4_px <= OPW'(sq_m.m22);
                r4_ry <= OPW'(sq_m.m10);
                r4_rx <= OPW'(sq_m.m00);
            end
        end
    end

    // singular flag rides alongside the CORDICs
    logic r_sing_dly [rmed_pkg::CO_LAT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing_dly[0] <= r4_sing;
            for (int k = 1; k < rmed_pkg::CO_LAT; k++) begin
                r_sing_dly[k] <= r_sing_dly[k-1];
            end
        end
    end

    logic p_vld, y_vld, rl_vld;
    logic [rmed_pkg::ANG_W-1:0] p_ang, y_ang, rl_ang;

    rmed_cordic u_pitch (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (r4_vld),
        .i_y (r4_py), .i_x (r4_px), .o_vld (p_vld), .o_ang (p_ang)
    );

    rmed_cordic u_yaw (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (r4_vld),
        .i_y (r4_yy), .i_x (r4_yx), .o_vld (y_vld), .o_ang (y_ang)
    );

    rmed_cordic u_roll (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (r4_vld),
        .i_y (r4_ry), .i_x (r4_rx), .o_vld (rl_vld), .o_ang (rl_ang)
    );

    assign o_valid       = p_vld;
    assign r_out_vld_any = y_vld | rl_vld;
    assign o_pitch_deg   = p_ang;
    assign o_yaw_deg     = y_ang;
    assign o_roll_deg    = rl_ang;
    assign o_is_singular = r_sing_dly[rmed_pkg::CO_LAT-1];

    // the three angle pipes stay in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid == y_vld) && (o_valid == rl_vld) && (r_out_vld_any == o_valid))
        else $error("angle pipelines out of step");

    a_roll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_singular) |-> (o_roll_deg == '0))
        else $error("roll not zero on singular beat");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_deg <= 16'sd23040 && o_pitch_deg >= -16'sd23040 &&
                     o_yaw_deg <= 16'sd23040 && o_yaw_deg >= -16'sd23040))
        else $error("angle outside +-180 degrees");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output beat");

endmodule

// File: rtl/rmed_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
module rmed_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [rmed_pkg::SQ_IN_W-1:0]    i_val,
    input  rmed_pkg::t_elems                i_side,
    output logic                            o_vld,
    output logic [rmed_pkg::SQ_OUT_W-1:0]   o_root,
    output rmed_pkg::t_elems                o_side
);

    localparam int N = rmed_pkg::SQ_OUT_W;

    logic                            r_vld  [N];
    logic [rmed_pkg::SQ_IN_W-1:0]    r_val  [N];
    logic [rmed_pkg::SQ_REM_W-1:0]   r_rem  [N];
    logic [rmed_pkg::SQ_OUT_W-1:0]   r_root [N];
    rmed_pkg::t_elems                r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                            s_vld;
        logic [rmed_pkg::SQ_IN_W-1:0]    s_val;
        logic [rmed_pkg::SQ_REM_W-1:0]   s_rem;
        logic [rmed_pkg::SQ_OUT_W-1:0]   s_root;
        rmed_pkg::t_elems                s_side;
        logic [rmed_pkg::SQ_REM_W+1:0]   n_sh;
        logic [rmed_pkg::SQ_REM_W+1:0]   n_trial;
        logic                            n_ge;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_val  = i_val;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_val  = r_val[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_side = r_side[k-1];
        end

        always_comb begin
            n_sh    = {s_rem, s_val[rmed_pkg::SQ_IN_W-1-2*k -: 2]};
            n_trial = {2'b00, s_root, 2'b01};
            n_ge    = (n_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
            if (i_en) begin
                r_val[k]  <= s_val;
                r_side[k] <= s_side;
                r_root[k] <= {s_root[rmed_pkg::SQ_OUT_W-2:0], n_ge};
                r_rem[k]  <= n_ge ? rmed_pkg::SQ_REM_W'(n_sh - n_trial)
                                  : rmed_pkg::SQ_REM_W'(n_sh);
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_side = r_side[N-1];

endmodule

// File: rtl/rmed_cordic.sv
// Pipelined vectoring CORDIC atan2 in degrees, rounded and saturated to Q9.7.
module rmed_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic signed [rmed_pkg::OPW-1:0]     i_y,
    input  logic signed [rmed_pkg::OPW-1:0]     i_x,
    output logic                                o_vld,
    output logic [rmed_pkg::ANG_W-1:0]          o_ang
);

    localparam int N  = rmed_pkg::CORDIC_STEPS;
    localparam int CW = rmed_pkg::CW;

    logic                  r_vld  [N+1];
    logic                  r_zero [N+1];
    logic signed [CW-1:0]  r_x    [N+1];
    logic signed [CW-1:0]  r_y    [N+1];
    logic signed [CW-1:0]  r_z    [N+1];
    logic                  r_ovld;
    logic [rmed_pkg::ANG_W-1:0] r_ang;

    // pre-stage: scale and fold the left half-plane
    logic signed [CW-1:0] n_xs, n_ys;
    always_comb begin
        n_xs = CW'(i_x) <<< rmed_pkg::PRESCALE_SH;
        n_ys = CW'(i_y) <<< rmed_pkg::PRESCALE_SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (n_xs < 0) begin
                if (n_ys >= 0) begin
                    r_x[0] <= n_ys;
                    r_y[0] <= -n_xs;
                    r_z[0] <= CW'(90) <<< rmed_pkg::ACC_FRAC;
                end else begin
                    r_x[0] <= -n_ys;
                    r_y[0] <= n_xs;
                    r_z[0] <= -(CW'(90) <<< rmed_pkg::ACC_FRAC);
                end
            end else begin
                r_x[0] <= n_xs;
                r_y[0] <= n_ys;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [CW-1:0] n_xsh, n_ysh;
        assign n_xsh = r_x[i] >>> i;
        assign n_ysh = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] + n_ysh;
                    r_y[i+1] <= r_y[i] - n_xsh;
                    r_z[i+1] <= r_z[i] + rmed_pkg::atan_deg(i);
                end else begin
                    r_x[i+1] <= r_x[i] - n_ysh;
                    r_y[i+1] <= r_y[i] + n_xsh;
                    r_z[i+1] <= r_z[i] - rmed_pkg::atan_deg(i);
                end
            end
        end
    end

    // round half up, saturate to +-180 degrees
    logic signed [CW-1:0] n_rnd;
    logic [rmed_pkg::ANG_W-1:0] n_ang;
    always_comb begin
        n_rnd = (r_z[N] + (CW'(1) <<< (rmed_pkg::RND_SH - 1))) >>> rmed_pkg::RND_SH;
        if (r_zero[N]) begin
            n_ang = '0;
        end else if (n_rnd > CW'(rmed_pkg::ANG_LIM)) begin
            n_ang = rmed_pkg::ANG_W'(rmed_pkg::ANG_LIM);
        end else if (n_rnd < -CW'(rmed_pkg::ANG_LIM)) begin
            n_ang = rmed_pkg::ANG_W'(-rmed_pkg::ANG_LIM);
        end else begin
            n_ang = n_rnd[rmed_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[N];
        end
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_vld = r_ovld;
    assign o_ang = r_ang;

endmodule

// File: dv/tb_rotation_matrix_to_euler_degrees_top.sv
// Testbench for the rotation matrix to Euler angle block: directed and random matrices.
`timescale 1ns / 100ps

module tb_rotation_matrix_to_euler_degrees_top;

    typedef struct {
        logic signed [rmed_pkg::ANG_W-1:0] pitch;
        logic signed [rmed_pkg::ANG_W-1:0] yaw;
        logic signed [rmed_pkg::ANG_W-1:0] roll;
        logic                              sing;
    } t_angles;

    // Scoreboard: predicts angles for each accepted matrix and checks results in order.
    class euler_scoreboard;
        t_angles        pending_angles[$];
        logic [rmed_pkg::THR_W-1:0] thr;
        int             n_err;
        int             n_checked;
        int             n_sing;

        function new();
            thr = 1;
            n_err = 0;
            n_checked = 0;
            n_sing = 0;
        endfunction

        function longint fshr(longint v, int s);
            fshr = v >>> s;
        endfunction

        function longint isqrt(longint v);
            longint res;
            longint b;
            res = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >>> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >>> 1) + b;
                end else begin
                    res = res >>> 1;
                end
                b = b >>> 2;
            end
            isqrt = res;
        endfunction

        function longint atan2_deg(longint y, longint x);
            longint z;
            longint t;
            longint xs;
            longint ys;
            longint lim;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x <<< rmed_pkg::PRESCALE_SH;
            y = y <<< rmed_pkg::PRESCALE_SH;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 64'sd90 <<< rmed_pkg::ACC_FRAC;
                end else begin
                    t = x; x = -y; y = t; z = -(64'sd90 <<< rmed_pkg::ACC_FRAC);
                end
            end
            for (int i = 0; i < rmed_pkg::CORDIC_STEPS; i++) begin
                xs = fshr(x, i);
                ys = fshr(y, i);
                if (y >= 0) begin
                    x += ys; y -= xs; z += rmed_pkg::ATAN_TAB[i];
                end else begin
                    x -= ys; y += xs; z -= rmed_pkg::ATAN_TAB[i];
                end
            end
            z = fshr(z + (64'sd1 <<< (rmed_pkg::RND_SH - 1)), rmed_pkg::RND_SH);
            lim = rmed_pkg::ANG_LIM;
            if (z > lim) z = lim;
            if (z < -lim) z = -lim;
            atan2_deg = z;
        endfunction

        function void note_matrix(rmed_pkg::t_elems m);
            t_angles a;
            longint sy;
            sy = isqrt(longint'(m.m00) * m.m00 + longint'(m.m20) * m.m20);
            a.sing = (sy < longint'(thr));
            a.yaw  = rmed_pkg::ANG_W'(atan2_deg(-longint'(m.m20), sy));
            if (!a.sing) begin
                a.pitch = rmed_pkg::ANG_W'(atan2_deg(m.m21, m.m22));
                a.roll  = rmed_pkg::ANG_W'(atan2_deg(m.m10, m.m00));
            end else begin
                a.pitch = rmed_pkg::ANG_W'(atan2_deg(-longint'(m.m12), m.m11));
                a.roll  = '0;
                n_sing++;
            end
            pending_angles = {pending_angles, a};
        endfunction

        function void check_angles(t_angles got);
            t_angles e;
            if (pending_angles.size() == 0) begin
                $error("unexpected result beat");
                n_err++;
                return;
            end
            e = pending_angles.pop_front();
            n_checked++;
            if (got.pitch !== e.pitch) begin
                $error("pitch_deg exp %0d got %0d", e.pitch, got.pitch); n_err++;
            end
            if (got.yaw !== e.yaw) begin
                $error("yaw_deg exp %0d got %0d", e.yaw, got.yaw); n_err++;
            end
            if (got.roll !== e.roll) begin
                $error("roll_deg exp %0d got %0d", e.roll, got.roll); n_err++;
            end
            if (got.sing !== e.sing) begin
                $error("is_singular exp %0b got %0b", e.sing, got.sing); n_err++;
            end
        endfunction
    endclass

    localparam int PIPE_LAT = 38;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    rmed_pkg::t_elems mat = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [rmed_pkg::ANG_W-1:0] o_pitch_deg, o_yaw_deg, o_roll_deg;
    logic o_is_singular;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [rmed_pkg::THR_W-1:0] i_cfg_data = '0;

    euler_scoreboard sb = new();
    bit hold_off = 1'b0;     // long receiver stall requested
    bit hold_done = 1'b0;    // long receiver stall carried out
    int n_sent = 0;

    always #6 i_clk = ~i_clk;

    rotation_matrix_to_euler_degrees_top u_dut (
        .i_clk, .i_rst_n,
        .i_valid, .o_stall,
        .i_m00(mat.m00), .i_m10(mat.m10), .i_m20(mat.m20), .i_m21(mat.m21),
        .i_m22(mat.m22), .i_m12(mat.m12), .i_m11(mat.m11),
        .o_valid, .i_stall,
        .o_pitch_deg, .o_yaw_deg, .o_roll_deg, .o_is_singular,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    // Monitor: sample both channels at the edge; note inputs before checking outputs.
    always @(posedge i_clk) begin
        t_angles got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_matrix(mat);
            if (o_valid && !i_stall) begin
                got.pitch = o_pitch_deg;
                got.yaw   = o_yaw_deg;
                got.roll  = o_roll_deg;
                got.sing  = o_is_singular;
                sb.check_angles(got);
            end
        end
    end

    // Receiver stall pattern: a phase of no stall, phases of light and heavy
    // random stall, and a long hold-off on request.
    always @(posedge i_clk) begin
        int hold_cnt;
        int r;
        if (hold_off && !hold_done) begin
            i_stall <= 1'b1;
            hold_cnt = 0;
            while (hold_cnt < 200) begin
                @(posedge i_clk);
                hold_cnt++;
            end
            hold_done = 1'b1;
            i_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            case ((n_sent / 200) % 3)
                0: i_stall <= 1'b0;
                1: i_stall <= (r < 30);
                default: i_stall <= (r < 70);
            endcase
        end
    end

    // Random element: mostly legal Q1.14 values, sometimes raw 16-bit patterns.
    function automatic rmed_pkg::t_elem rnd_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return rmed_pkg::t_elem'($urandom);
        if (r == 1) return rmed_pkg::t_elem'(0);
        if (r == 2) return ($urandom_range(0, 1)) ? rmed_pkg::t_elem'(16384)
                                                  : rmed_pkg::t_elem'(-16384);
        if (r == 3) return rmed_pkg::t_elem'($urandom_range(0, 64)) - rmed_pkg::t_elem'(32);
        return rmed_pkg::t_elem'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // Drive one matrix beat and wait until it is accepted.
    task automatic send_matrix(rmed_pkg::t_elems m);
        i_valid <= 1'b1;
        mat <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_angles.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [rmed_pkg::THR_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.thr = v;
    endtask

    task automatic random_burst(int count, bit near_sing);
        rmed_pkg::t_elems m;
        int gap;
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                m.m00 = rnd_elem(); m.m10 = rnd_elem(); m.m20 = rnd_elem();
                m.m21 = rnd_elem(); m.m22 = rnd_elem(); m.m12 = rnd_elem();
                m.m11 = rnd_elem();
                if (near_sing && $urandom_range(0, 1)) begin
                    m.m00 = rmed_pkg::t_elem'($urandom_range(0, 600)) - rmed_pkg::t_elem'(300);
                    m.m20 = rmed_pkg::t_elem'($urandom_range(0, 600)) - rmed_pkg::t_elem'(300);
                end
                send_matrix(m);
                burst--;
                count--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        rmed_pkg::t_elems d;
        rmed_pkg::t_elem ext[6];
        ext = '{16384, -16384, 0, 32767, -32768, 1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero matrix, identity, extremes, negative x with zero y,
        // gimbal lock with roll forced to zero.
        send_matrix('0);
        d = '{16384, 0, 0, 0, 16384, 0, 16384};
        send_matrix(d);
        d = '{-16384, 0, 0, 0, -16384, 0, -16384};
        send_matrix(d);
        d = '{0, 1000, 16384, 5, -7, 300, -200};
        send_matrix(d);
        d = '{0, 1000, -16384, -5, 0, -300, 0};
        send_matrix(d);
        d = '{0, 77, 0, 9, 9, 16384, 0};
        send_matrix(d);
        for (int k = 0; k < 6; k++) begin
            d = '{ext[k], ext[(k+1)%6], ext[(k+2)%6], ext[(k+3)%6],
                  ext[(k+4)%6], ext[(k+5)%6], ext[k]};
            send_matrix(d);
            d = '{ext[k], -ext[(k+1)%6], ext[k], -ext[(k+3)%6],
                  ext[(k+2)%6], ext[(k+4)%6], -ext[(k+5)%6]};
            send_matrix(d);
        end
        d = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(d);
        d = '{32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(d);
        drain_and_settle();

        random_burst(300, 1'b0);
        // Long receiver hold-off while the sender keeps offering beats.
        hold_off = 1'b1;
        random_burst(150, 1'b0);
        drain_and_settle();

        write_threshold(15'd0);
        random_burst(200, 1'b1);
        drain_and_settle();
        write_threshold(15'd16384);
        random_burst(200, 1'b0);
        drain_and_settle();
        write_threshold(15'd200);
        random_burst(250, 1'b1);
        drain_and_settle();
        write_threshold(15'h7FFF);
        random_burst(100, 1'b0);
        drain_and_settle();
        write_threshold(15'd1);
        random_burst(100, 1'b1);
        drain_and_settle();

        $display("Run covered %0d matrices, %0d results checked, %0d singular,",
                 n_sent, sb.n_checked, sb.n_sing);
        $display("over five threshold settings with random stalls and a long hold-off.");
        if (sb.n_err == 0 && sb.pending_angles.size() == 0) begin
            $display("PASS rotation_matrix_to_euler_degrees_top");
        end else begin
            $display("FAIL rotation_matrix_to_euler_degrees_top");
        end
        $finish;
    end

    initial begin
        #(12ns * 400000);
        $display("FAIL rotation_matrix_to_euler_degrees_top");
        $finish;
    end

endmodule
